/* rtl/mspwm_pkg.sv */
// ----------------------------------------------------------------------------
// mspwm_pkg
// Shared types and constants for the two-channel mark-space pwm block:
// request kinds, register offsets, control bit positions and channel structs.
// ----------------------------------------------------------------------------
package mspwm_pkg;

    // default widths handed to the top level parameters
    localparam int COUNTER_WIDTH_DEF = 32;
    localparam int DIVISOR_WIDTH_DEF = 12;

    // stream payload widths
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 1;

    // request kinds
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // areas
    localparam logic AREA_PWM = 1'b0;
    localparam logic AREA_CLK = 1'b1;

    // pwm area offsets
    localparam logic [7:0] OFF_CTL   = 8'd0;
    localparam logic [7:0] OFF_STA   = 8'd4;
    localparam logic [7:0] OFF_RNG_A = 8'd16;
    localparam logic [7:0] OFF_DAT_A = 8'd20;
    localparam logic [7:0] OFF_RNG_B = 8'd32;
    localparam logic [7:0] OFF_DAT_B = 8'd36;

    // clock area offsets
    localparam logic [7:0] OFF_CM_CTL = 8'd160;
    localparam logic [7:0] OFF_CM_DIV = 8'd164;

    // clock manager password in the top byte
    localparam logic [7:0] CLK_PASSWORD = 8'h5a;

    // control word bit positions
    localparam int CTL_EN_A  = 0;
    localparam int CTL_SIL_A = 3;
    localparam int CTL_POL_A = 4;
    localparam int CTL_CLRF  = 6;
    localparam int CTL_EN_B  = 8;
    localparam int CTL_SIL_B = 11;
    localparam int CTL_POL_B = 12;

    // status bit positions
    localparam int STA_ACT_A = 9;
    localparam int STA_ACT_B = 10;

    // clock control bit positions
    localparam int CLK_ENABLE = 4;
    localparam int CLK_BUSY   = 7;

    // divisor field position in the divisor register
    localparam int DIV_LSB = 12;

    // per-channel control bits, taken from the control word
    typedef struct packed {
        logic en;
        logic sil;
        logic pol;
    } chan_ctl_t;

    // per-channel register write strobes
    typedef struct packed {
        logic period;
        logic duty;
    } chan_wr_t;

endpackage

/* rtl/mspwm_channel.sv */
// ----------------------------------------------------------------------------
// mspwm_channel
// One mark-space channel: range, duty and counter registers, with the level
// that the channel drives once the current transfer has been applied.
// ----------------------------------------------------------------------------
module mspwm_channel
    import mspwm_pkg::*;
#(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,       // divided clock for this channel
    input  chan_wr_t                 wr,         // qualified register writes
    input  logic [COUNTER_WIDTH-1:0] wr_data,
    input  chan_ctl_t                ctl,        // control bits after this transfer
    output logic [COUNTER_WIDTH-1:0] period,
    output logic [COUNTER_WIDTH-1:0] duty,
    output logic                     level_next
);

    logic [COUNTER_WIDTH-1:0] period_reg;
    logic [COUNTER_WIDTH-1:0] duty_reg;
    logic [COUNTER_WIDTH-1:0] count_reg;
    logic [COUNTER_WIDTH-1:0] period_next;
    logic [COUNTER_WIDTH-1:0] duty_next;
    logic [COUNTER_WIDTH-1:0] count_next;
    logic [COUNTER_WIDTH:0]   count_inc;
    logic                     wrap;
    logic                     mark_inc;
    logic                     mark_hold;
    logic                     mark;

    // register writes
    assign period_next = wr.period ? wr_data : period_reg;
    assign duty_next   = wr.duty ? wr_data : duty_reg;

    // counter step and wrap, with both level candidates in parallel
    assign count_inc = {1'b0, count_reg} + {{COUNTER_WIDTH{1'b0}}, 1'b1};
    assign wrap      = count_inc >= {1'b0, period_reg};
    assign mark_inc  = wrap ? (duty_reg != '0) : (count_inc < {1'b0, duty_reg});
    assign mark_hold = count_reg < duty_next;

    always_comb
    begin
        if (step)
        begin
            count_next = wrap ? '0 : count_inc[COUNTER_WIDTH-1:0];
            mark       = mark_inc;
        end
        else
        begin
            count_next = count_reg;
            mark       = mark_hold;
        end
    end

    // output level: disabled channel drives its silence bit
    assign level_next = ctl.en ? (mark ^ ctl.pol) : ctl.sil;

    // channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= '0;
            duty_reg   <= '0;
            count_reg  <= '0;
        end
        else
        begin
            period_reg <= period_next;
            duty_reg   <= duty_next;
            count_reg  <= count_next;
        end
    end

    assign period = period_reg;
    assign duty   = duty_reg;

endmodule

/* rtl/two_channel_mark_space_pwm.sv */
// ----------------------------------------------------------------------------
// two_channel_mark_space_pwm
// Two-channel mark-space pwm with a clock divider, driven by a stream of
// tick, register write and register read requests; one result per request.
//
//   channel   direction  tdata (low bit up)                 tuser
//   s_axis    in         offset[7:0], write_data[39:8]       req_type[1:0], area[2]
//   m_axis    out        read_data[31:0], pwm_out_a[32],     access_error[0]
//                        pwm_out_b[33], zeros[39:34]
//
// One request per cycle sustained while the output is not stalled; an input
// transfer reaches its result through the input register, then the result register.
// Register updates and the result are formed combinationally between the
// two registers, so a request sees everything the previous one left.
// rst_n clears valid flags, control and channel state; payload registers are not reset; clock divisor resets to one.
// A stalled output holds the result and the input register; new input is
// taken whenever the pipeline can move.
// ----------------------------------------------------------------------------
module two_channel_mark_space_pwm
    import mspwm_pkg::*;
#(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF,
    parameter int DIVISOR_WIDTH = DIVISOR_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // offset, write_data
    input  logic [IN_TUSER_W-1:0]  s_tuser,   // req_type, area
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // read_data, pwm_out_a, pwm_out_b, zeros
    output logic [OUT_TUSER_W-1:0] m_tuser    // access_error
);

    // input register
    logic        in_valid_reg;
    logic [1:0]  req_reg;
    logic        area_reg;
    logic [7:0]  offset_reg;
    logic [31:0] wdata_reg;

    // result register
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        out_a_reg;
    logic        out_b_reg;
    logic        out_err_reg;

    // block state
    logic [15:0]              cw_reg;
    logic [15:0]              cw_next;
    logic [7:0]               cc_reg;
    logic [7:0]               cc_next;
    logic [DIVISOR_WIDTH-1:0] div_reg;
    logic [DIVISOR_WIDTH-1:0] div_next;
    logic [DIVISOR_WIDTH-1:0] pre_reg;
    logic [DIVISOR_WIDTH-1:0] pre_next;

    logic                     advance;
    logic                     proc;
    logic                     is_tick;
    logic                     is_wr;
    logic                     is_rd;
    logic                     pw_ok;
    logic                     ok;
    logic [31:0]              rd_data;
    logic [DIVISOR_WIDTH-1:0] pre_inc;
    logic [DIVISOR_WIDTH-1:0] div_eff;
    logic                     fire;
    logic                     div_clk;
    chan_wr_t                 wr_a;
    chan_wr_t                 wr_b;
    chan_ctl_t                ctl_a;
    chan_ctl_t                ctl_b;
    logic [COUNTER_WIDTH-1:0] period_a;
    logic [COUNTER_WIDTH-1:0] duty_a;
    logic [COUNTER_WIDTH-1:0] period_b;
    logic [COUNTER_WIDTH-1:0] duty_b;
    logic                     level_a;
    logic                     level_b;

    // handshake
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign proc     = in_valid_reg && advance;

    assign is_tick = proc && (req_reg == REQ_TICK);
    assign is_wr   = proc && (req_reg == REQ_WRITE);
    assign is_rd   = proc && (req_reg == REQ_READ);

    // clock divider
    assign pre_inc = pre_reg + {{(DIVISOR_WIDTH-1){1'b0}}, 1'b1};
    assign div_eff = (div_reg == '0) ? {{(DIVISOR_WIDTH-1){1'b0}}, 1'b1} : div_reg;
    assign fire    = (pre_inc == '0) || (pre_inc >= div_eff);
    assign div_clk = is_tick && cc_reg[CLK_ENABLE] && fire;

    always_comb
    begin
        pre_next = pre_reg;
        if (is_tick && cc_reg[CLK_ENABLE])
        begin
            pre_next = fire ? '0 : pre_inc;
        end
    end

    // register writes and clock password check
    assign pw_ok = wdata_reg[31:24] == CLK_PASSWORD;

    always_comb
    begin
        cw_next  = cw_reg;
        cc_next  = cc_reg;
        div_next = div_reg;
        wr_a     = '0;
        wr_b     = '0;
        if (is_wr && area_reg == AREA_PWM)
        begin
            case (offset_reg)
                OFF_CTL:
                begin
                    cw_next           = wdata_reg[15:0];
                    cw_next[CTL_CLRF] = 1'b0;
                end
                OFF_RNG_A: wr_a.period = 1'b1;
                OFF_DAT_A: wr_a.duty   = 1'b1;
                OFF_RNG_B: wr_b.period = 1'b1;
                OFF_DAT_B: wr_b.duty   = 1'b1;
                default:   cw_next     = cw_reg;
            endcase
        end
        if (is_wr && area_reg == AREA_CLK && pw_ok)
        begin
            case (offset_reg)
                OFF_CM_CTL: cc_next  = {wdata_reg[CLK_ENABLE], wdata_reg[6:0]};
                OFF_CM_DIV: div_next = wdata_reg[DIV_LSB +: DIVISOR_WIDTH];
                default:    cc_next  = cc_reg;
            endcase
        end
    end

    // read mux and access check
    always_comb
    begin
        rd_data = '0;
        ok      = 1'b1;
        if (area_reg == AREA_PWM)
        begin
            case (offset_reg)
                OFF_CTL:   rd_data = {16'b0, cw_reg};
                OFF_STA:
                begin
                    rd_data[STA_ACT_A] = cw_reg[CTL_EN_A];
                    rd_data[STA_ACT_B] = cw_reg[CTL_EN_B];
                end
                OFF_RNG_A: rd_data = 32'(period_a);
                OFF_DAT_A: rd_data = 32'(duty_a);
                OFF_RNG_B: rd_data = 32'(period_b);
                OFF_DAT_B: rd_data = 32'(duty_b);
                default:   ok      = 1'b0;
            endcase
        end
        else
        begin
            case (offset_reg)
                OFF_CM_CTL: rd_data = {24'b0, cc_reg};
                OFF_CM_DIV: rd_data = 32'({div_reg, {DIV_LSB{1'b0}}});
                default:    ok      = 1'b0;
            endcase
            if (req_reg == REQ_WRITE && !pw_ok)
            begin
                ok = 1'b0;
            end
        end
        if (req_reg == REQ_TICK)
        begin
            ok = 1'b1;
        end
        else if (req_reg != REQ_WRITE && req_reg != REQ_READ)
        begin
            ok = 1'b0;
        end
        if (!is_rd || !ok)
        begin
            rd_data = '0;
        end
    end

    // channel control bits after this transfer
    assign ctl_a = '{en: cw_next[CTL_EN_A], sil: cw_next[CTL_SIL_A], pol: cw_next[CTL_POL_A]};
    assign ctl_b = '{en: cw_next[CTL_EN_B], sil: cw_next[CTL_SIL_B], pol: cw_next[CTL_POL_B]};

    // channels
    mspwm_channel #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_chan_a (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (div_clk && cw_reg[CTL_EN_A]),
        .wr         (wr_a),
        .wr_data    (wdata_reg[COUNTER_WIDTH-1:0]),
        .ctl        (ctl_a),
        .period     (period_a),
        .duty       (duty_a),
        .level_next (level_a)
    );

    mspwm_channel #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_chan_b (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (div_clk && cw_reg[CTL_EN_B]),
        .wr         (wr_b),
        .wr_data    (wdata_reg[COUNTER_WIDTH-1:0]),
        .ctl        (ctl_b),
        .period     (period_b),
        .duty       (duty_b),
        .level_next (level_b)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cw_reg        <= '0;
            cc_reg        <= '0;
            div_reg       <= {{(DIVISOR_WIDTH-1){1'b0}}, 1'b1};
            pre_reg       <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            cw_reg  <= cw_next;
            cc_reg  <= cc_next;
            div_reg <= div_next;
            pre_reg <= pre_next;
        end
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            req_reg    <= s_tuser[1:0];
            area_reg   <= s_tuser[2];
            offset_reg <= s_tdata[7:0];
            wdata_reg  <= s_tdata[39:8];
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            out_data_reg <= rd_data;
            out_a_reg    <= level_a;
            out_b_reg    <= level_b;
            out_err_reg  <= !ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-34){1'b0}}, out_b_reg, out_a_reg, out_data_reg};
    assign m_tuser  = out_err_reg;

endmodule
